/* design/hucq_pkg.sv */
// Package for the hierarchical update coalescing queue.
// Holds queue depths, identifier width, command codes and the cell types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hucq_pkg;

    localparam int USER_DEPTH    = 16;
    localparam int DEVICE_DEPTH  = 32;
    localparam int CHANNEL_DEPTH = 64;
    localparam int ID_BITS       = 31;

    typedef logic [ID_BITS-1:0] id_t;

    typedef enum logic [2:0] {
        CMD_FULL    = 3'd0,
        CMD_USER    = 3'd1,
        CMD_DEVICE  = 3'd2,
        CMD_CHANNEL = 3'd3,
        CMD_TAKE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        LVL_FULL    = 2'd0,
        LVL_USER    = 2'd1,
        LVL_DEVICE  = 2'd2,
        LVL_CHANNEL = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMPACT
    } state_t;

    typedef struct packed {
        id_t owner;
        id_t unit;
        id_t point;
    } entry_t;

    // Control broadcast to every cell of one row
    typedef struct packed {
        logic flush;
        logic pop;
        logic compact;
        logic append;
        logic purge;
        logic purge_unit;
    } ctl_t;

endpackage : hucq_pkg
`default_nettype wire

/* design/hucq_cell.sv */
// One queue slot: entry, valid bit, match logic and neighbour shift.
// Depends on hucq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hucq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  hucq_pkg::ctl_t   ctl,
    input  hucq_pkg::entry_t key,
    input  hucq_pkg::entry_t nb_entry,
    input  logic            nb_valid,
    input  logic            prev_valid,
    input  logic            hole_in,
    output hucq_pkg::entry_t entry,
    output logic            valid,
    output logic            hole_out,
    output logic            gap,
    output logic            owner_hit,
    output logic            unit_hit,
    output logic            point_hit
);
    import hucq_pkg::*;

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   shift, kill, load;

    assign owner_hit = valid_reg && (entry_reg.owner == key.owner);
    assign unit_hit  = valid_reg && (entry_reg.unit == key.unit);
    assign point_hit = valid_reg && (entry_reg.point == key.point);

    // Everything above the first hole moves down one slot per cycle
    assign shift = ctl.pop || (ctl.compact && (hole_in || !valid_reg));
    assign kill  = ctl.purge && owner_hit && (!ctl.purge_unit || unit_hit);
    assign load  = ctl.append && !valid_reg && prev_valid;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            entry_next = nb_entry;
            valid_next = nb_valid;
        end
        else if (kill)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            entry_next = key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign valid    = valid_reg;
    assign hole_out = hole_in || !valid_reg;
    assign gap      = hole_in && valid_reg;

endmodule : hucq_cell
`default_nettype wire

/* design/hierarchical_update_coalescing_queue.sv */
// Top level: command sequencer and three rows of queue cells.
// Depends on hucq_pkg and hucq_cell.
//
// Usage: present command and ids with start high; the transaction is taken
// at a clock edge where busy is low. Commands 0..3 queue refresh requests
// and give no result. Command 4 (take) gives one result, marked by done for
// one cycle and registered in the execute state; the receiver cannot stall it.
// Each item passes an execute state, then a compaction state that lasts
// while a purge has left a hole below a live entry; a pop leaves no hole.
// While compacting, rows shift entries above the first hole one slot a cycle.
// The user must write configuration (cfg_write, cfg_index, cfg_data) only
// when idle; the block does not enforce it. The four allow bits reset to 1.
// Reset empties all rows, clears the full-refresh flag and the sticky
// overflow flag and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_update_coalescing_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               command,
    input  hucq_pkg::id_t            owner_id,
    input  hucq_pkg::id_t            unit_id,
    input  hucq_pkg::id_t            point_id,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic                     cfg_data,
    output logic                     done,
    output logic                     found,
    output logic [1:0]               level,
    output hucq_pkg::id_t            out_owner,
    output hucq_pkg::id_t            out_unit,
    output hucq_pkg::id_t            out_point,
    output logic                     overflowed
);
    import hucq_pkg::*;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    entry_t key_reg;
    logic   allow_full_reg, allow_user_reg, allow_dev_reg, allow_ch_reg;
    logic   full_pending_reg, full_pending_next;
    logic   overflow_reg, overflow_next;
    logic   done_reg, done_next, found_reg, found_next;
    level_t level_reg, level_next;
    entry_t out_reg, out_next;
    ctl_t   u_ctl, d_ctl, c_ctl;

    entry_t u_entry [USER_DEPTH];
    logic   u_valid [USER_DEPTH];
    logic   u_hole  [USER_DEPTH];
    logic [USER_DEPTH-1:0] u_gap, u_ohit;

    entry_t d_entry [DEVICE_DEPTH];
    logic   d_valid [DEVICE_DEPTH];
    logic   d_hole  [DEVICE_DEPTH];
    logic [DEVICE_DEPTH-1:0] d_gap, d_ohit, d_uhit;

    entry_t c_entry [CHANNEL_DEPTH];
    logic   c_valid [CHANNEL_DEPTH];
    logic   c_hole  [CHANNEL_DEPTH];
    logic [CHANNEL_DEPTH-1:0] c_gap, c_ohit, c_uhit, c_phit;

    logic user_has, dev_has, ch_has, need_compact;

    genvar gi;
    generate
        for (gi = 0; gi < USER_DEPTH; gi++)
        begin : g_user
            logic pu, ph;
            hucq_cell u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(u_ctl), .key(key_reg),
                .nb_entry((gi == USER_DEPTH-1) ? entry_t'('0) : u_entry[(gi+1)%USER_DEPTH]),
                .nb_valid((gi == USER_DEPTH-1) ? 1'b0 : u_valid[(gi+1)%USER_DEPTH]),
                .prev_valid((gi == 0) ? 1'b1 : u_valid[(gi+USER_DEPTH-1)%USER_DEPTH]),
                .hole_in((gi == 0) ? 1'b0 : u_hole[(gi+USER_DEPTH-1)%USER_DEPTH]),
                .entry(u_entry[gi]), .valid(u_valid[gi]), .hole_out(u_hole[gi]),
                .gap(u_gap[gi]), .owner_hit(u_ohit[gi]), .unit_hit(pu), .point_hit(ph)
            );
        end
        for (gi = 0; gi < DEVICE_DEPTH; gi++)
        begin : g_dev
            logic ph;
            hucq_cell d_cell (
                .clk(clk), .rst_n(rst_n), .ctl(d_ctl), .key(key_reg),
                .nb_entry((gi == DEVICE_DEPTH-1) ? entry_t'('0)
                          : d_entry[(gi+1)%DEVICE_DEPTH]),
                .nb_valid((gi == DEVICE_DEPTH-1) ? 1'b0 : d_valid[(gi+1)%DEVICE_DEPTH]),
                .prev_valid((gi == 0) ? 1'b1
                            : d_valid[(gi+DEVICE_DEPTH-1)%DEVICE_DEPTH]),
                .hole_in((gi == 0) ? 1'b0 : d_hole[(gi+DEVICE_DEPTH-1)%DEVICE_DEPTH]),
                .entry(d_entry[gi]), .valid(d_valid[gi]), .hole_out(d_hole[gi]),
                .gap(d_gap[gi]), .owner_hit(d_ohit[gi]), .unit_hit(d_uhit[gi]),
                .point_hit(ph)
            );
        end
        for (gi = 0; gi < CHANNEL_DEPTH; gi++)
        begin : g_ch
            hucq_cell c_cell (
                .clk(clk), .rst_n(rst_n), .ctl(c_ctl), .key(key_reg),
                .nb_entry((gi == CHANNEL_DEPTH-1) ? entry_t'('0)
                          : c_entry[(gi+1)%CHANNEL_DEPTH]),
                .nb_valid((gi == CHANNEL_DEPTH-1) ? 1'b0
                          : c_valid[(gi+1)%CHANNEL_DEPTH]),
                .prev_valid((gi == 0) ? 1'b1
                            : c_valid[(gi+CHANNEL_DEPTH-1)%CHANNEL_DEPTH]),
                .hole_in((gi == 0) ? 1'b0 : c_hole[(gi+CHANNEL_DEPTH-1)%CHANNEL_DEPTH]),
                .entry(c_entry[gi]), .valid(c_valid[gi]), .hole_out(c_hole[gi]),
                .gap(c_gap[gi]), .owner_hit(c_ohit[gi]), .unit_hit(c_uhit[gi]),
                .point_hit(c_phit[gi])
            );
        end
    endgenerate

    // Device rows match on unit alone, channel rows on point alone
    assign user_has     = |u_ohit;
    assign dev_has      = |d_uhit;
    assign ch_has       = |c_phit;
    assign need_compact = (|u_gap) || (|d_gap) || (|c_gap);

    always_comb
    begin
        state_next        = state_reg;
        full_pending_next = full_pending_reg;
        overflow_next     = overflow_reg;
        done_next         = 1'b0;
        found_next        = found_reg;
        level_next        = level_reg;
        out_next          = out_reg;
        u_ctl             = '0;
        d_ctl             = '0;
        c_ctl             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_COMPACT;
                case (cmd_reg)
                    CMD_FULL:
                    begin
                        if (allow_full_reg && !full_pending_reg)
                        begin
                            full_pending_next = 1'b1;
                            u_ctl.flush = 1'b1;
                            d_ctl.flush = 1'b1;
                            c_ctl.flush = 1'b1;
                        end
                    end
                    CMD_USER:
                    begin
                        if (allow_user_reg && !full_pending_reg && !user_has)
                        begin
                            if (u_valid[USER_DEPTH-1])
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                u_ctl.append = 1'b1;
                                d_ctl.purge  = 1'b1;
                                c_ctl.purge  = 1'b1;
                            end
                        end
                    end
                    CMD_DEVICE:
                    begin
                        if (allow_dev_reg && !full_pending_reg && !user_has && !dev_has)
                        begin
                            if (d_valid[DEVICE_DEPTH-1])
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                d_ctl.append     = 1'b1;
                                c_ctl.purge      = 1'b1;
                                c_ctl.purge_unit = 1'b1;
                            end
                        end
                    end
                    CMD_CHANNEL:
                    begin
                        if (allow_ch_reg && !full_pending_reg && !user_has && !dev_has
                            && !ch_has)
                        begin
                            if (c_valid[CHANNEL_DEPTH-1])
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                c_ctl.append = 1'b1;
                            end
                        end
                    end
                    CMD_TAKE:
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b1;
                        level_next = LVL_FULL;
                        out_next   = '0;
                        if (full_pending_reg)
                        begin
                            full_pending_next = 1'b0;
                        end
                        else if (u_valid[0])
                        begin
                            level_next      = LVL_USER;
                            out_next.owner  = u_entry[0].owner;
                            u_ctl.pop       = 1'b1;
                        end
                        else if (d_valid[0])
                        begin
                            level_next      = LVL_DEVICE;
                            out_next.owner  = d_entry[0].owner;
                            out_next.unit   = d_entry[0].unit;
                            d_ctl.pop       = 1'b1;
                        end
                        else if (c_valid[0])
                        begin
                            level_next = LVL_CHANNEL;
                            out_next   = c_entry[0];
                            c_ctl.pop  = 1'b1;
                        end
                        else
                        begin
                            found_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_COMPACT:
            begin
                u_ctl.compact = 1'b1;
                d_ctl.compact = 1'b1;
                c_ctl.compact = 1'b1;
                if (!need_compact)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            full_pending_reg <= 1'b0;
            overflow_reg     <= 1'b0;
            done_reg         <= 1'b0;
            allow_full_reg   <= 1'b1;
            allow_user_reg   <= 1'b1;
            allow_dev_reg    <= 1'b1;
            allow_ch_reg     <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            full_pending_reg <= full_pending_next;
            overflow_reg     <= overflow_next;
            done_reg         <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    2'd0: allow_full_reg <= cfg_data;
                    2'd1: allow_user_reg <= cfg_data;
                    2'd2: allow_dev_reg  <= cfg_data;
                    2'd3: allow_ch_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        level_reg <= level_next;
        out_reg   <= out_next;
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg <= cmd_t'(command);
            key_reg <= '{owner: owner_id, unit: unit_id, point: point_id};
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign level      = level_reg;
    assign out_owner  = out_reg.owner;
    assign out_unit   = out_reg.unit;
    assign out_point  = out_reg.point;
    assign overflowed = overflow_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC && cmd_reg == CMD_TAKE))
        else $error("result without a take");

    a_idle_compact: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !need_compact)
        else $error("idle with holes in a queue");

    a_full_empties: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && full_pending_reg |-> !u_valid[0] && !d_valid[0] && !c_valid[0])
        else $error("queue entries alongside a pending full refresh");

endmodule : hierarchical_update_coalescing_queue
`default_nettype wire

/* verif/hierarchical_update_coalescing_queue_tb.sv */
// Self-checking testbench for hierarchical_update_coalescing_queue.
// Randomised and directed refresh requests checked against a behavioural queue model.
// Depends on hucq_pkg and the design files.
`timescale 1ns / 1ps
module hierarchical_update_coalescing_queue_tb;
    import hucq_pkg::*;

    typedef struct {
        logic [2:0] cmd;
        id_t        owner;
        id_t        unit;
        id_t        point;
    } request_t;

    typedef struct {
        logic   found;
        level_t lvl;
        id_t    owner;
        id_t    unit;
        id_t    point;
        logic   ovf;
    } grant_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 3 + CHANNEL_DEPTH + 20;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] command;
    id_t        owner_id;
    id_t        unit_id;
    id_t        point_id;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       cfg_data;
    logic       done;
    logic       found;
    logic [1:0] level;
    id_t        out_owner;
    id_t        out_unit;
    id_t        out_point;
    logic       overflowed;

    hierarchical_update_coalescing_queue DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .owner_id(owner_id), .unit_id(unit_id), .point_id(point_id),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .found(found), .level(level), .out_owner(out_owner),
        .out_unit(out_unit), .out_point(out_point), .overflowed(overflowed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    int       errors = 0;
    int       cycles = 0;
    bit       no_idle = 0;

    // Mirror of the queue state
    logic allow[4];
    logic full_flag, ovf_flag;
    id_t  usr_q[USER_DEPTH];
    int   usr_n;
    id_t  dev_o[DEVICE_DEPTH], dev_u[DEVICE_DEPTH];
    int   dev_n;
    id_t  ch_o[CHANNEL_DEPTH], ch_u[CHANNEL_DEPTH], ch_p[CHANNEL_DEPTH];
    int   ch_n;

    function automatic bit user_queued(id_t o);
        for (int i = 0; i < usr_n; i++)
            if (usr_q[i] == o) return 1;
        return 0;
    endfunction

    function automatic bit unit_queued(id_t u);
        for (int i = 0; i < dev_n; i++)
            if (dev_u[i] == u) return 1;
        return 0;
    endfunction

    function automatic bit point_queued(id_t p);
        for (int i = 0; i < ch_n; i++)
            if (ch_p[i] == p) return 1;
        return 0;
    endfunction

    // Drop channel entries of an owner, optionally only those of one unit
    function automatic void drop_channels(id_t o, bit by_unit, id_t u);
        int k;
        k = 0;
        for (int i = 0; i < ch_n; i++)
            if (!(ch_o[i] == o && (!by_unit || ch_u[i] == u)))
            begin
                ch_o[k] = ch_o[i];
                ch_u[k] = ch_u[i];
                ch_p[k] = ch_p[i];
                k++;
            end
        ch_n = k;
    endfunction

    function automatic void queue_update(request_t r);
        grant_t g;
        int     k;
        g = '{1'b1, LVL_FULL, '0, '0, '0, 1'b0};
        case (r.cmd)
            CMD_FULL:
                if (allow[0] && !full_flag)
                begin
                    full_flag = 1;
                    usr_n = 0;
                    dev_n = 0;
                    ch_n = 0;
                end
            CMD_USER:
                if (allow[1] && !full_flag && !user_queued(r.owner))
                begin
                    if (usr_n >= USER_DEPTH)
                        ovf_flag = 1;
                    else
                    begin
                        usr_q[usr_n++] = r.owner;
                        k = 0;
                        for (int i = 0; i < dev_n; i++)
                            if (dev_o[i] != r.owner)
                            begin
                                dev_o[k] = dev_o[i];
                                dev_u[k] = dev_u[i];
                                k++;
                            end
                        dev_n = k;
                        drop_channels(r.owner, 0, '0);
                    end
                end
            CMD_DEVICE:
                if (allow[2] && !full_flag && !user_queued(r.owner) && !unit_queued(r.unit))
                begin
                    if (dev_n >= DEVICE_DEPTH)
                        ovf_flag = 1;
                    else
                    begin
                        dev_o[dev_n] = r.owner;
                        dev_u[dev_n] = r.unit;
                        dev_n++;
                        drop_channels(r.owner, 1, r.unit);
                    end
                end
            CMD_CHANNEL:
                if (allow[3] && !full_flag && !user_queued(r.owner) && !unit_queued(r.unit)
                    && !point_queued(r.point))
                begin
                    if (ch_n >= CHANNEL_DEPTH)
                        ovf_flag = 1;
                    else
                    begin
                        ch_o[ch_n] = r.owner;
                        ch_u[ch_n] = r.unit;
                        ch_p[ch_n] = r.point;
                        ch_n++;
                    end
                end
            CMD_TAKE:
            begin
                if (full_flag)
                    full_flag = 0;
                else if (usr_n > 0)
                begin
                    g.lvl = LVL_USER;
                    g.owner = usr_q[0];
                    for (int i = 1; i < usr_n; i++) usr_q[i-1] = usr_q[i];
                    usr_n--;
                end
                else if (dev_n > 0)
                begin
                    g.lvl = LVL_DEVICE;
                    g.owner = dev_o[0];
                    g.unit = dev_u[0];
                    for (int i = 1; i < dev_n; i++)
                    begin
                        dev_o[i-1] = dev_o[i];
                        dev_u[i-1] = dev_u[i];
                    end
                    dev_n--;
                end
                else if (ch_n > 0)
                begin
                    g.lvl = LVL_CHANNEL;
                    g.owner = ch_o[0];
                    g.unit = ch_u[0];
                    g.point = ch_p[0];
                    for (int i = 1; i < ch_n; i++)
                    begin
                        ch_o[i-1] = ch_o[i];
                        ch_u[i-1] = ch_u[i];
                        ch_p[i-1] = ch_p[i];
                    end
                    ch_n--;
                end
                else
                    g.found = 0;
                g.ovf = ovf_flag;
                expected_grants.insert(expected_grants.size(), g);
            end
            default: ;
        endcase
    endfunction

    // Driver: hold a transaction until accepted, then idle or present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= CMD_TAKE;
            owner_id <= '0;
            unit_id <= '0;
            point_id <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                queue_update('{command, owner_id, unit_id, point_id});
                pending_reqs.delete(0);
            end
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 27))
            begin
                start <= 1'b1;
                command <= pending_reqs[0].cmd;
                owner_id <= pending_reqs[0].owner;
                unit_id <= pending_reqs[0].unit;
                point_id <= pending_reqs[0].point;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                grant_t g;
                g = expected_grants[0];
                expected_grants.delete(0);
                if (found !== g.found)
                begin
                    $error("found: expected %0d, got %0d", g.found, found);
                    errors++;
                end
                if (level !== g.lvl)
                begin
                    $error("level: expected %0d, got %0d", g.lvl, level);
                    errors++;
                end
                if (out_owner !== g.owner)
                begin
                    $error("out_owner: expected %0h, got %0h", g.owner, out_owner);
                    errors++;
                end
                if (out_unit !== g.unit)
                begin
                    $error("out_unit: expected %0h, got %0h", g.unit, out_unit);
                    errors++;
                end
                if (out_point !== g.point)
                begin
                    $error("out_point: expected %0h, got %0h", g.point, out_point);
                    errors++;
                end
                if (overflowed !== g.ovf)
                begin
                    $error("overflowed: expected %0d, got %0d", g.ovf, overflowed);
                    errors++;
                end
            end
        end
    end

    // Small pools give plenty of coalescing; the rest covers every id bit
    function automatic id_t pick_id(int pool);
        int r;
        r = $urandom_range(99);
        if (r < 70) return id_t'($urandom_range(pool - 1));
        if (r < 80) return '1;
        if (r < 85) return '0;
        return id_t'($urandom);
    endfunction

    task automatic push_req(logic [2:0] c, id_t o, id_t u, id_t p);
        request_t r;
        r = '{c, o, u, p};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic push_random(int n);
        int r;
        logic [2:0] c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 28) c = CMD_TAKE;
            else if (r < 32) c = CMD_FULL;
            else if (r < 45) c = CMD_USER;
            else if (r < 65) c = CMD_DEVICE;
            else if (r < 95) c = CMD_CHANNEL;
            else c = 3'($urandom_range(5, 7));
            push_req(c, pick_id(4), pick_id(8), pick_id(16));
        end
    endtask

    // Distinct requests of one kind to fill a queue past its depth, then drain
    task automatic push_flood(logic [2:0] c, int n);
        id_t base;
        base = id_t'($urandom);
        for (int i = 0; i < n; i++)
            push_req(c, base + id_t'(i), base + id_t'(i), base + id_t'(i));
        for (int i = 0; i < n; i++)
            push_req(CMD_TAKE, '0, '0, '0);
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || start || expected_grants.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_allow(logic [3:0] bits);
        wait_quiet();
        // requests give no result, so the block may still be compacting
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= bits[i];
            allow[i] = bits[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] settings[6];
        settings = '{4'b0000, 4'b0101, 4'b1010, 4'b1110, 4'b0111, 4'b1111};
        for (int i = 0; i < 4; i++) allow[i] = 1;
        full_flag = 0;
        ovf_flag = 0;
        usr_n = 0;
        dev_n = 0;
        ch_n = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty take, full twice, extremes, duplicates and purges
        push_req(CMD_TAKE, '0, '0, '0);
        push_req(CMD_FULL, '0, '0, '0);
        push_req(CMD_FULL, '1, '1, '1);
        push_req(CMD_USER, '1, '0, '0);
        push_req(CMD_TAKE, '0, '0, '0);
        push_req(CMD_TAKE, '0, '0, '0);
        push_req(CMD_CHANNEL, '1, '0, '1);
        push_req(CMD_CHANNEL, 31'd5, 31'd6, '1);
        push_req(CMD_CHANNEL, '1, '1, '0);
        push_req(CMD_DEVICE, '1, '0, '0);
        push_req(CMD_DEVICE, 31'd9, '0, '0);
        push_req(CMD_DEVICE, '0, '1, '0);
        push_req(CMD_USER, '0, '0, '0);
        push_req(CMD_USER, '0, '1, '1);
        push_req(CMD_CHANNEL, '0, 31'd3, 31'd3);
        push_req(3'd5, '1, '1, '1);
        push_req(3'd7, '0, '0, '0);
        for (int i = 0; i < 6; i++) push_req(CMD_TAKE, '0, '0, '0);

        push_flood(CMD_USER, USER_DEPTH + 2);
        push_flood(CMD_DEVICE, DEVICE_DEPTH + 2);
        push_flood(CMD_CHANNEL, CHANNEL_DEPTH + 2);
        push_random(250);
        wait_quiet();

        no_idle = 1;
        push_random(150);
        wait_quiet();
        no_idle = 0;

        for (int s = 0; s < 6; s++)
        begin
            set_allow(settings[s]);
            push_random(110);
        end
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
design/hucq_pkg.sv
design/hucq_cell.sv
design/hierarchical_update_coalescing_queue.sv
verif/hierarchical_update_coalescing_queue_tb.sv
